/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros shared by the frame checker rtl
// clock and reset are taken from the names clk and arst_n in scope
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check, disabled while in reset
`define HFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define HFC_ASSERT_IMPL(lbl, ante, cons, msg) \
	`HFC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* src/hfc_pkg.sv */
// ----------------------------------------------------------------------------
// hfc_pkg
// types, constants and the crc-8 byte update for the frame checker
// ----------------------------------------------------------------------------
package hfc_pkg;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// byte positions within a frame
	localparam logic [2:0] POS_T_HI  = 3'd0;
	localparam logic [2:0] POS_T_LO  = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_HI  = 3'd3;
	localparam logic [2:0] POS_H_LO  = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	// conversion constants, hundredths
	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [14:0] HUM_SCALE   = 15'd10000;
	localparam logic [14:0] TEMP_OFFSET = 15'd4500;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TEMP_CRC = 2'd1,
		STATUS_HUM_CRC  = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] raw_temperature;
		logic [15:0] raw_humidity;
	} frame_t;

	// msb-first crc-8 update over one byte, no reflection
	function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] b);
		logic [7:0] c;
		c = crc_in ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* src/hfc_in_if.sv */
// ----------------------------------------------------------------------------
// hfc_in_if
// byte channel into the frame checker
// ----------------------------------------------------------------------------
interface hfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

/* src/hfc_out_if.sv */
// ----------------------------------------------------------------------------
// hfc_out_if
// result channel out of the frame checker
// ----------------------------------------------------------------------------
interface hfc_out_if;
	logic               valid;
	logic               ready;
	hfc_pkg::status_t   status;
	logic [15:0]        raw_temperature;
	logic [15:0]        raw_humidity;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;

	modport source (
		output valid, output status, output raw_temperature, output raw_humidity,
		output temperature_centi, output humidity_centi, input ready
	);
	modport sink (
		input valid, input status, input raw_temperature, input raw_humidity,
		input temperature_centi, input humidity_centi, output ready
	);
endinterface

/* src/hfc_frame.sv */
// ----------------------------------------------------------------------------
// hfc_frame
// input register, byte sequencer with running crc, frame result register
// ----------------------------------------------------------------------------
module hfc_frame (
	input  logic          clk,
	input  logic          arst_n,
	hfc_in_if.sink        rx,
	input  logic          adv,
	output logic          res_valid,
	output hfc_pkg::frame_t res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;

	logic [2:0]  byte_position_q;
	logic [7:0]  running_crc_q;
	logic [15:0] temperature_word_q;
	logic [15:0] humidity_word_q;
	logic        temperature_crc_bad_q;

	logic            valid_s2;
	hfc_pkg::frame_t frame_s2;

	logic       consume;
	logic [2:0] pos;
	logic [7:0] crc_base;
	logic [7:0] crc_next;
	logic       last;
	logic       hum_bad;

	assign consume  = !valid_s2 || adv;
	assign rx.ready = !valid_s1 || consume;

	always_comb begin
		pos = start_s1 ? hfc_pkg::POS_T_HI : byte_position_q;
		if (pos > hfc_pkg::POS_H_CRC) begin
			pos = hfc_pkg::POS_T_HI;
		end
		crc_base = start_s1 ? hfc_pkg::CRC_INIT : running_crc_q;
		// word high bytes always start a fresh crc
		crc_next = hfc_pkg::crc_byte(
			((pos == hfc_pkg::POS_T_HI) || (pos == hfc_pkg::POS_H_HI)) ?
				hfc_pkg::CRC_INIT : crc_base, byte_s1);
		last    = (pos == hfc_pkg::POS_H_CRC);
		hum_bad = (crc_base != byte_s1);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1  <= rx.rx_byte;
			start_s1 <= rx.frame_start;
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q       <= hfc_pkg::POS_T_HI;
			running_crc_q         <= hfc_pkg::CRC_INIT;
			temperature_word_q    <= 16'd0;
			humidity_word_q       <= 16'd0;
			temperature_crc_bad_q <= 1'b0;
		end else if (valid_s1 && consume) begin
			byte_position_q <= last ? hfc_pkg::POS_T_HI : 3'(pos + 3'd1);
			case (pos)
				hfc_pkg::POS_T_HI: begin
					running_crc_q            <= crc_next;
					temperature_word_q[15:8] <= byte_s1;
				end
				hfc_pkg::POS_T_LO: begin
					running_crc_q           <= crc_next;
					temperature_word_q[7:0] <= byte_s1;
				end
				hfc_pkg::POS_T_CRC: begin
					temperature_crc_bad_q <= (crc_base != byte_s1);
					running_crc_q         <= hfc_pkg::CRC_INIT;
				end
				hfc_pkg::POS_H_HI: begin
					running_crc_q         <= crc_next;
					humidity_word_q[15:8] <= byte_s1;
				end
				hfc_pkg::POS_H_LO: begin
					running_crc_q        <= crc_next;
					humidity_word_q[7:0] <= byte_s1;
				end
				default: begin
					running_crc_q <= hfc_pkg::CRC_INIT;
				end
			endcase
		end
	end

	// frame result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (consume) begin
			valid_s2 <= valid_s1 && last;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && valid_s1 && last) begin
			frame_s2.raw_temperature <= temperature_word_q;
			frame_s2.raw_humidity    <= humidity_word_q;
			if (temperature_crc_bad_q) begin
				frame_s2.status <= hfc_pkg::STATUS_TEMP_CRC;
			end else if (hum_bad) begin
				frame_s2.status <= hfc_pkg::STATUS_HUM_CRC;
			end else begin
				frame_s2.status <= hfc_pkg::STATUS_OK;
			end
		end
	end

	assign res_valid = valid_s2;
	assign res       = frame_s2;

endmodule

/* src/hfc_convert.sv */
// ----------------------------------------------------------------------------
// hfc_convert
// scaling multiply stage, divide by 65535 and offset, output register
// ----------------------------------------------------------------------------
module hfc_convert (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  hfc_pkg::frame_t in_frame,
	output logic            adv,
	hfc_out_if.source       result
);

	logic             valid_s3;
	hfc_pkg::status_t status_s3;
	logic [15:0]      raw_t_s3;
	logic [15:0]      raw_h_s3;
	logic [30:0]      t_prod_s3;
	logic [29:0]      h_prod_s3;

	logic               valid_q;
	hfc_pkg::status_t   status_q;
	logic [15:0]        raw_t_q;
	logic [15:0]        raw_h_q;
	logic signed [14:0] t_centi_q;
	logic [13:0]        h_centi_q;

	logic        out_en;
	logic [15:0] t_quot;
	logic [15:0] h_quot;

	// exact floor(p / 65535) while the quotient stays below 65536
	function automatic logic [15:0] div_65535(input logic [31:0] p);
		logic [31:0] s;
		s = p + {16'd0, p[31:16]} + 32'd1;
		return s[31:16];
	endfunction

	assign out_en = !valid_q || result.ready;
	assign adv    = !valid_s3 || out_en;

	assign t_quot = div_65535(32'(t_prod_s3));
	assign h_quot = div_65535(32'(h_prod_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				valid_s3 <= in_valid;
			end
			if (out_en) begin
				valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			status_s3 <= in_frame.status;
			raw_t_s3  <= in_frame.raw_temperature;
			raw_h_s3  <= in_frame.raw_humidity;
			t_prod_s3 <= 31'(in_frame.raw_temperature) * 31'(hfc_pkg::TEMP_SCALE);
			h_prod_s3 <= 30'(in_frame.raw_humidity) * 30'(hfc_pkg::HUM_SCALE);
		end
		if (out_en && valid_s3) begin
			status_q  <= status_s3;
			raw_t_q   <= raw_t_s3;
			raw_h_q   <= raw_h_s3;
			t_centi_q <= signed'(15'(t_quot[14:0] - hfc_pkg::TEMP_OFFSET));
			h_centi_q <= h_quot[13:0];
		end
	end

	assign result.valid             = valid_q;
	assign result.status            = status_q;
	assign result.raw_temperature   = raw_t_q;
	assign result.raw_humidity      = raw_h_q;
	assign result.temperature_centi = t_centi_q;
	assign result.humidity_centi    = h_centi_q;

endmodule

/* src/humidity_frame_check_convert_core.sv */
// the result beat passes the frame result, multiply and output registers after the sixth byte is taken
// throughput: one byte beat per cycle while the result channel does not stall, one result per six bytes, no bubbles
// the rate is set by the unrolled crc byte update between input and frame registers
// reset: arst_n clears all valids, byte count, crc to 0xff and the stored words
// ----------------------------------------------------------------------------
// humidity_frame_check_convert_core
// crc-checked temperature and humidity frame decoder with centi conversion
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module humidity_frame_check_convert_core (
	input  logic      clk,
	input  logic      arst_n,
	hfc_in_if.sink    rx,
	hfc_out_if.source result
);

	// frame sequencer to converter
	logic            frame_valid;
	hfc_pkg::frame_t frame;
	logic            conv_adv;

	// byte stage: input register, crc and word capture, frame result register
	hfc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.adv       (conv_adv),
		.res_valid (frame_valid),
		.res       (frame)
	);

	// conversion stage: constant multiply, divide by 65535, offset, output beat
	hfc_convert u_convert (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame_valid),
		.in_frame (frame),
		.adv      (conv_adv),
		.result   (result)
	);

	// with the output free the whole pipe moves, so the input is always ready
	`HFC_ASSERT_IMPL(a_ready_when_free, (!result.valid || result.ready), rx.ready, "input stalled with free output")
	`HFC_ASSERT_IMPL(a_hum_range, result.valid, (result.humidity_centi <= 14'd10000), "humidity out of range")
	`HFC_ASSERT_IMPL(a_temp_range, result.valid, ((result.temperature_centi >= -15'sd4500) && (result.temperature_centi <= 15'sd13000)), "temperature out of range")
	`HFC_ASSERT_IMPL(a_status_code, result.valid, (result.status <= hfc_pkg::STATUS_HUM_CRC), "bad status code")

endmodule

/* tb/tb_humidity_frame_check_convert_core.sv */
// ----------------------------------------------------------------------------
// tb_humidity_frame_check_convert_core
// self-checking bench for the crc-checked temperature and humidity decoder:
// frames go in one byte beat at a time, a cycle-free model of the byte
// sequencer predicts each six-byte result, and every result beat is compared
// field by field under several sender and receiver stall patterns
// ----------------------------------------------------------------------------
module tb_humidity_frame_check_convert_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;	// leave ample margin for the output to drain
	localparam int MAX_GAP = 8;

	// one decoded reading as it should appear on the result channel
	typedef struct {
		hfc_pkg::status_t   status;
		logic [15:0]        raw_t;
		logic [15:0]        raw_h;
		logic signed [14:0] t_centi;
		logic [13:0]        h_centi;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;

	hfc_in_if  rx_if ();
	hfc_out_if res_if ();

	humidity_frame_check_convert_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (res_if)
	);

	// readings waiting for their result beat, oldest first
	reading_t pending_readings[$];

	// shadow of the frame sequencer state
	logic [2:0]  m_pos;
	logic [7:0]  m_crc;
	logic [15:0] m_tword;
	logic [15:0] m_hword;
	logic        m_tbad;

	int src_idle_pct;
	int sink_stall_pct;
	int bytes_sent;
	int mismatch_count;
	int cycle_count;

	// ------------------------------------------------------------------------
	// clock, and a watchdog in case a handshake never completes
	// ------------------------------------------------------------------------
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("humidity_frame_check_convert_core verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// crc-8, poly 0x31, bit-serial form: feed data msb first into the register
	// ------------------------------------------------------------------------
	function automatic logic [7:0] crc8_31(input logic [7:0] acc, input logic [7:0] data);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int k = 7; k >= 0; k--) begin
			fb = r[7] ^ data[k];
			r = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ hfc_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	function automatic logic [7:0] word_crc(input logic [15:0] w);
		return crc8_31(crc8_31(hfc_pkg::CRC_INIT, w[15:8]), w[7:0]);
	endfunction

	// ------------------------------------------------------------------------
	// sequencer model: advance on one accepted byte beat, queue a reading
	// when the humidity crc byte closes the frame
	// ------------------------------------------------------------------------
	task automatic predict_frame_byte(input logic [7:0] b, input logic fs);
		logic        hbad;
		int unsigned t_scaled;
		int unsigned h_scaled;
		reading_t    r;
		if (fs) begin
			m_pos = hfc_pkg::POS_T_HI;
			m_crc = hfc_pkg::CRC_INIT;
		end
		// positions 6 and 7 behave as the start of a frame
		if (m_pos > hfc_pkg::POS_H_CRC) begin
			m_pos = hfc_pkg::POS_T_HI;
		end
		case (m_pos)
			hfc_pkg::POS_T_HI: begin
				m_crc = crc8_31(hfc_pkg::CRC_INIT, b);
				m_tword[15:8] = b;
			end
			hfc_pkg::POS_T_LO: begin
				m_crc = crc8_31(m_crc, b);
				m_tword[7:0] = b;
			end
			hfc_pkg::POS_T_CRC: begin
				m_tbad = (m_crc != b);
				m_crc = hfc_pkg::CRC_INIT;
			end
			hfc_pkg::POS_H_HI: begin
				m_crc = crc8_31(hfc_pkg::CRC_INIT, b);
				m_hword[15:8] = b;
			end
			hfc_pkg::POS_H_LO: begin
				m_crc = crc8_31(m_crc, b);
				m_hword[7:0] = b;
			end
			default: begin
			end
		endcase
		if (m_pos != hfc_pkg::POS_H_CRC) begin
			m_pos = m_pos + 3'd1;
		end else begin
			hbad = (m_crc != b);
			m_pos = hfc_pkg::POS_T_HI;
			m_crc = hfc_pkg::CRC_INIT;
			// floor scaling in hundredths, temperature offset by -45.00
			t_scaled = (32'd17500 * m_tword) / 32'd65535;
			h_scaled = (32'd10000 * m_hword) / 32'd65535;
			if (m_tbad) begin
				r.status = hfc_pkg::STATUS_TEMP_CRC;
			end else if (hbad) begin
				r.status = hfc_pkg::STATUS_HUM_CRC;
			end else begin
				r.status = hfc_pkg::STATUS_OK;
			end
			r.raw_t   = m_tword;
			r.raw_h   = m_hword;
			r.t_centi = 15'(int'(t_scaled) - 4500);
			r.h_centi = 14'(h_scaled);
			pending_readings.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------------
	// byte sender: optional idle gap, then hold the beat until it is taken;
	// called just after a rising edge, returns at the accepting edge
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic fs);
		int gaps;
		gaps = 0;
		while (gaps < MAX_GAP && $urandom_range(99) < src_idle_pct) begin
			if (gaps == 0) begin
				rx_if.valid <= 1'b0;
			end
			rx_if.rx_byte     <= 8'($urandom);
			rx_if.frame_start <= 1'($urandom);
			@(posedge clk);
			gaps++;
		end
		rx_if.valid       <= 1'b1;
		rx_if.rx_byte     <= b;
		rx_if.frame_start <= fs;
		do begin
			@(posedge clk);
		end while (!rx_if.ready);
		predict_frame_byte(b, fs);
		bytes_sent++;
	endtask

	// a whole frame; a non-zero flip corrupts that crc byte
	task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
			input logic [7:0] t_flip, input logic [7:0] h_flip, input logic fs);
		send_byte(tw[15:8], fs);
		send_byte(tw[7:0], 1'b0);
		send_byte(word_crc(tw) ^ t_flip, 1'b0);
		send_byte(hw[15:8], 1'b0);
		send_byte(hw[7:0], 1'b0);
		send_byte(word_crc(hw) ^ h_flip, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// result side: random stalls on ready, check each taken beat
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		reading_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (pending_readings.size() == 0) begin
					report_mismatch("result beat with no frame outstanding");
				end else begin
					want = pending_readings.pop_front();
					if (res_if.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							res_if.status, want.status));
					if (res_if.raw_temperature !== want.raw_t)
						report_mismatch($sformatf("raw_temperature %h, want %h",
							res_if.raw_temperature, want.raw_t));
					if (res_if.raw_humidity !== want.raw_h)
						report_mismatch($sformatf("raw_humidity %h, want %h",
							res_if.raw_humidity, want.raw_h));
					if (res_if.temperature_centi !== want.t_centi)
						report_mismatch($sformatf("temperature_centi %0d, want %0d",
							res_if.temperature_centi, want.t_centi));
					if (res_if.humidity_centi !== want.h_centi)
						report_mismatch($sformatf("humidity_centi %0d, want %0d",
							res_if.humidity_centi, want.h_centi));
				end
			end
			res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------------

	// conversion end points: 0 gives -45.00 degC, 0xffff gives 100.00 %rh
	task automatic test_conversion_extremes();
		send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00, 1'b1);
	endtask

	// both crcs bad (temperature wins), back to back with no frame_start,
	// then a humidity-only crc error at mid-scale words
	task automatic test_crc_errors();
		send_frame(16'hFFFF, 16'h0000, 8'h01, 8'h80, 1'b0);
		send_frame(16'h8000, 16'h8000, 8'h00, 8'hFF, 1'b1);
	endtask

	// frame_start throws away a half-received frame
	task automatic test_restart_mid_frame();
		send_byte(8'hAB, 1'b1);
		send_byte(8'hCD, 1'b0);
		send_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 1'b1);
	endtask

	// ------------------------------------------------------------------------
	// random traffic: mostly clean frames, then corrupted, cut-short and noise
	// ------------------------------------------------------------------------
	function automatic logic [15:0] pick_word();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8) return 16'h0000;
		if (sel < 16) return 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic test_random_traffic(input int n_bytes);
		int kind;
		int cut;
		int stop_at;
		logic [15:0] tw;
		logic [15:0] hw;
		logic [7:0]  frame_bytes[6];
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			kind = $urandom_range(99);
			tw = pick_word();
			hw = pick_word();
			if (kind < 60) begin
				send_frame(tw, hw, 8'h00, 8'h00, 1'($urandom));
			end else if (kind < 70) begin
				send_frame(tw, hw, 8'($urandom_range(1, 255)), 8'h00, 1'($urandom));
			end else if (kind < 80) begin
				send_frame(tw, hw, 8'h00, 8'($urandom_range(1, 255)), 1'($urandom));
			end else if (kind < 85) begin
				send_frame(tw, hw, 8'($urandom_range(1, 255)),
					8'($urandom_range(1, 255)), 1'($urandom));
			end else if (kind < 93) begin
				// frame cut short, the next one must resync
				frame_bytes = '{tw[15:8], tw[7:0], word_crc(tw), hw[15:8], hw[7:0],
					word_crc(hw)};
				cut = $urandom_range(1, 5);
				for (int i = 0; i < cut; i++) begin
					send_byte(frame_bytes[i], i == 0);
				end
			end else begin
				// line noise with stray frame_start flags
				cut = $urandom_range(1, 6);
				for (int i = 0; i < cut; i++) begin
					send_byte(8'($urandom), $urandom_range(99) < 30);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// sequence of tests
	// ------------------------------------------------------------------------
	initial begin
		arst_n            <= 1'b0;
		rx_if.valid       <= 1'b0;
		rx_if.rx_byte     <= 8'h00;
		rx_if.frame_start <= 1'b0;
		cycle_count       = 0;
		mismatch_count    = 0;
		bytes_sent        = 0;
		src_idle_pct      = 0;
		sink_stall_pct    = 0;
		m_pos             = hfc_pkg::POS_T_HI;
		m_crc             = hfc_pkg::CRC_INIT;
		m_tword           = 16'h0000;
		m_hword           = 16'h0000;
		m_tbad            = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with both sides free-running
		test_conversion_extremes();
		test_crc_errors();
		test_restart_mid_frame();

		// random part under each stall pattern
		test_random_traffic(440);
		src_idle_pct = 45;
		test_random_traffic(440);
		src_idle_pct = 0;
		sink_stall_pct = 45;
		test_random_traffic(440);
		src_idle_pct = 22;
		sink_stall_pct = 22;
		test_random_traffic(440);

		rx_if.valid <= 1'b0;
		wait (pending_readings.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_readings.size() == 0) begin
			$display("humidity_frame_check_convert_core verification clean");
		end else begin
			$display("humidity_frame_check_convert_core verification failed");
		end
		$finish;
	end

endmodule

/* humidity_frame_check_convert_core.f */
+incdir+src
src/hfc_pkg.sv
src/hfc_in_if.sv
src/hfc_out_if.sv
src/hfc_frame.sv
src/hfc_convert.sv
src/humidity_frame_check_convert_core.sv
tb/tb_humidity_frame_check_convert_core.sv
